### hw/rtl/mmn_pkg.sv
// Shared types, constants and helpers for the memory map normalizer.
package mmn_pkg;

  localparam int unsigned MaxRegions = 32;
  localparam int unsigned IdxW       = $clog2(MaxRegions);
  localparam int unsigned CntW       = $clog2(MaxRegions + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam logic [2:0] KindUsable = 3'd0;
  localparam logic [2:0] KindKernel = 3'd6;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic [2:0]  kind;
  } region_t;

  // Memory access request from the sequencer to the region store.
  typedef struct packed {
    logic              we;
    logic              snap;   // select blocker snapshot memory
    logic [IdxW-1:0]   waddr;
    region_t           wdata;
    logic [IdxW-1:0]   raddr;
    logic              rsnap;  // read from snapshot memory
  } mem_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SNAP_RD,
    ST_SNAP_WR,
    ST_CARVE_SRD,
    ST_CARVE_SWAIT,
    ST_CARVE_RD,
    ST_CARVE_EVAL,
    ST_CARVE_TAIL,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_SORT_RDKEY,
    ST_SORT_KEY,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_JOIN_RD,
    ST_JOIN_WR,
    ST_JOIN_LAST,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_EMIT_RD,
    ST_EMIT,
    ST_EMPTY
  } state_e;

  function automatic logic [2:0] prio_of(input logic [2:0] k);
    logic [2:0] p;
    case (k)
      3'd6:    p = 3'd6;
      3'd4:    p = 3'd5;
      3'd3:    p = 3'd4;
      3'd2:    p = 3'd3;
      3'd1:    p = 3'd2;
      3'd5:    p = 3'd1;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

### hw/rtl/mmn_store.sv
// Region table and blocker snapshot memories, with a registered read.
module mmn_store import mmn_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output region_t  rdata_o
);

  region_t tbl_mem  [MaxRegions];
  region_t snap_mem [MaxRegions];

  // Write one memory, read either one.
  always_ff @(posedge clk_i) begin
    if (req_i.we && !req_i.snap) tbl_mem[req_i.waddr] <= req_i.wdata;
    if (req_i.we && req_i.snap)  snap_mem[req_i.waddr] <= req_i.wdata;
    rdata_o <= req_i.rsnap ? snap_mem[req_i.raddr] : tbl_mem[req_i.raddr];
  end

endmodule

### hw/rtl/memory_map_normalizer.sv
// Top level of the memory map normalizer: sequencer around the region store.
// Clear and add words leave the sequencer idle; busy stays low, so one per cycle.
// A finish word runs a pass over the table while busy: snapshot and carving per blocker
// (a split adds a tail entry), compaction, insertion sort, join and totals, all through
// the single memory read port; then one result per cycle, each marked by strobe.
// Reset clears the entry count, the drop counter and the sequencer; the
// memories are not cleared. Results cannot be stalled by the receiver.
module memory_map_normalizer import mmn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [63:0] base_i,
  input  logic [63:0] size_i,
  input  logic [2:0]  kind_i,
  output logic        strobe,
  output logic        region_valid_o,
  output logic [63:0] region_base_o,
  output logic [63:0] region_size_o,
  output logic [2:0]  region_kind_o,
  output logic        last_o,
  output logic [5:0]  region_total_o,
  output logic [63:0] usable_total_o,
  output logic [63:0] mapped_total_o,
  output logic [15:0] dropped_count_o
);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;       // entry count
  logic [15:0]     drop_q, drop_d;
  logic [CntW-1:0] i_q, i_d;           // scan index
  logic [CntW-1:0] j_q, j_d;           // second index (compaction write, sort, join count)
  logic [CntW-1:0] b_q, b_d;           // blocker index
  logic [CntW-1:0] nb_q, nb_d;         // blocker count
  region_t         a_q, a_d;           // held region (blocker, key, join head)
  region_t         t_q, t_d;           // pending region (append / tail)
  logic [63:0]     us_q, us_d, mp_q, mp_d;
  mem_req_t        req;
  region_t         rd;

  mmn_store u_store (.clk_i(clk_i), .req_i(req), .rdata_o(rd));

  logic accept;
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Carve evaluation on the entry just read.
  logic [63:0] bs, be, eus, eue;
  logic        hit, cov_lo, cov_hi;
  assign bs     = a_q.base;
  assign be     = a_q.base + a_q.size;
  assign eus    = rd.base;
  assign eue    = rd.base + rd.size;
  assign hit    = (rd.size != '0) && (prio_of(rd.kind) < prio_of(a_q.kind))
                  && !(be <= eus || eue <= bs);
  assign cov_lo = (bs <= eus);
  assign cov_hi = (be >= eue);

  logic [IdxW-1:0] i_ix, j_ix, b_ix, c_ix;
  assign i_ix = i_q[IdxW-1:0];
  assign j_ix = j_q[IdxW-1:0];
  assign b_ix = b_q[IdxW-1:0];
  assign c_ix = cnt_q[IdxW-1:0];

  logic [CntW-1:0] one;
  assign one = CntW'(1);

  // Next state and register updates.
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; drop_d = drop_q;
    i_d = i_q; j_d = j_q; b_d = b_q; nb_d = nb_q;
    a_d = a_q; t_d = t_q; us_d = us_q; mp_d = mp_q;
    req = '0;
    unique case (state_q)
      ST_IDLE: if (accept) begin
        unique case (op_e'(operation_i))
          OP_CLEAR: begin cnt_d = '0; drop_d = '0; end
          OP_ADD: if (size_i != '0) begin
            if (cnt_q >= CntW'(MaxRegions)) begin
              if (drop_q != 16'hFFFF) drop_d = drop_q + 16'd1;
            end else begin
              req.we = 1'b1; req.waddr = c_ix;
              req.wdata = '{base: base_i, size: size_i, kind: kind_i};
              cnt_d = cnt_q + one;
            end
          end
          OP_FINISH: begin
            t_d = '{base: base_i, size: size_i, kind: KindKernel};
            state_d = ST_APPEND;
          end
          default: ;
        endcase
      end
      ST_APPEND: begin
        if (t_q.size != '0) begin
          if (cnt_q >= CntW'(MaxRegions)) begin
            if (drop_q != 16'hFFFF) drop_d = drop_q + 16'd1;
          end else begin
            req.we = 1'b1; req.waddr = c_ix; req.wdata = t_q;
            cnt_d = cnt_q + one;
          end
        end
        i_d = '0; nb_d = '0;
        state_d = ST_SNAP_RD;
      end
      // Copy blockers to the snapshot memory.
      ST_SNAP_RD: begin
        if (i_q >= cnt_q) begin b_d = '0; state_d = ST_CARVE_SRD; end
        else begin req.raddr = i_ix; state_d = ST_SNAP_WR; end
      end
      ST_SNAP_WR: begin
        if (prio_of(rd.kind) != 3'd0) begin
          req.we = 1'b1; req.snap = 1'b1; req.waddr = nb_q[IdxW-1:0];
          req.wdata = rd; nb_d = nb_q + one;
        end
        i_d = i_q + one; state_d = ST_SNAP_RD;
      end
      // Walk each blocker over the table.
      ST_CARVE_SRD: begin
        if (b_q >= nb_q) begin i_d = '0; j_d = '0; state_d = ST_COMP_RD; end
        else begin req.raddr = b_ix; req.rsnap = 1'b1; state_d = ST_CARVE_SWAIT; end
      end
      ST_CARVE_SWAIT: begin a_d = rd; i_d = '0; state_d = ST_CARVE_RD; end
      ST_CARVE_RD: begin
        if (i_q >= cnt_q) begin b_d = b_q + one; state_d = ST_CARVE_SRD; end
        else begin req.raddr = i_ix; state_d = ST_CARVE_EVAL; end
      end
      ST_CARVE_EVAL: begin
        state_d = ST_CARVE_RD;
        i_d = i_q + one;
        if (hit) begin
          req.we = 1'b1; req.waddr = i_ix; req.wdata = rd;
          if (cov_lo && cov_hi) req.wdata.size = '0;
          else if (cov_lo) begin
            req.wdata.base = be; req.wdata.size = eue - be;
          end else if (cov_hi) req.wdata.size = bs - eus;
          else begin
            req.wdata.size = bs - eus;
            t_d = '{base: be, size: eue - be, kind: rd.kind};
            state_d = ST_CARVE_TAIL;
          end
        end
      end
      ST_CARVE_TAIL: begin
        if (t_q.size != '0) begin
          if (cnt_q >= CntW'(MaxRegions)) begin
            if (drop_q != 16'hFFFF) drop_d = drop_q + 16'd1;
          end else begin
            req.we = 1'b1; req.waddr = c_ix; req.wdata = t_q;
            cnt_d = cnt_q + one;
          end
        end
        state_d = ST_CARVE_RD;
      end
      // Drop empty entries.
      ST_COMP_RD: begin
        if (i_q >= cnt_q) begin cnt_d = j_q; i_d = one; state_d = ST_SORT_RDKEY; end
        else begin req.raddr = i_ix; state_d = ST_COMP_WR; end
      end
      ST_COMP_WR: begin
        if (rd.size != '0) begin
          req.we = 1'b1; req.waddr = j_ix; req.wdata = rd; j_d = j_q + one;
        end
        i_d = i_q + one; state_d = ST_COMP_RD;
      end
      // Insertion sort by base.
      ST_SORT_RDKEY: begin
        if (i_q >= cnt_q) begin i_d = '0; j_d = '0; state_d = ST_JOIN_RD; end
        else begin req.raddr = i_ix; state_d = ST_SORT_KEY; end
      end
      ST_SORT_KEY: begin a_d = rd; j_d = i_q; state_d = ST_SORT_RD; end
      ST_SORT_RD: begin
        if (j_q == '0) state_d = ST_SORT_PUT;
        else begin req.raddr = IdxW'(j_q - one); state_d = ST_SORT_CMP; end
      end
      ST_SORT_CMP: begin
        if (rd.base > a_q.base) begin
          req.we = 1'b1; req.waddr = j_ix; req.wdata = rd;
          j_d = j_q - one; state_d = ST_SORT_RD;
        end else state_d = ST_SORT_PUT;
      end
      ST_SORT_PUT: begin
        req.we = 1'b1; req.waddr = j_ix; req.wdata = a_q;
        i_d = i_q + one; state_d = ST_SORT_RDKEY;
      end
      // Merge touching same-kind neighbors; a_q holds the open region.
      ST_JOIN_RD: begin
        if (i_q >= cnt_q) state_d = ST_JOIN_LAST;
        else begin req.raddr = i_ix; state_d = ST_JOIN_WR; end
      end
      ST_JOIN_WR: begin
        if (j_q != '0 && a_q.kind == rd.kind && a_q.base + a_q.size == rd.base)
          a_d.size = a_q.size + rd.size;
        else begin
          if (j_q != '0) begin
            req.we = 1'b1; req.waddr = IdxW'(j_q - one); req.wdata = a_q;
          end
          a_d = rd; j_d = j_q + one;
        end
        i_d = i_q + one; state_d = ST_JOIN_RD;
      end
      ST_JOIN_LAST: begin
        if (j_q != '0) begin
          req.we = 1'b1; req.waddr = IdxW'(j_q - one); req.wdata = a_q;
        end
        cnt_d = j_q; i_d = '0; us_d = '0; mp_d = '0;
        state_d = (j_q == '0) ? ST_EMPTY : ST_SUM_RD;
      end
      // Totals, then emission.
      ST_SUM_RD: begin
        if (i_q >= cnt_q) begin i_d = '0; state_d = ST_EMIT_RD; end
        else begin req.raddr = i_ix; state_d = ST_SUM_ACC; end
      end
      ST_SUM_ACC: begin
        mp_d = mp_q + rd.size;
        if (rd.kind == KindUsable) us_d = us_q + rd.size;
        i_d = i_q + one; state_d = ST_SUM_RD;
      end
      ST_EMIT_RD: begin req.raddr = i_ix; state_d = ST_EMIT; end
      ST_EMIT: begin
        i_d = i_q + one;
        if (i_q + one >= cnt_q) state_d = ST_IDLE;
        else begin req.raddr = IdxW'(i_q + one); state_d = ST_EMIT; end
      end
      ST_EMPTY: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Result ports.
  always_comb begin
    strobe          = (state_q == ST_EMIT) || (state_q == ST_EMPTY);
    region_valid_o  = (state_q == ST_EMIT);
    region_base_o   = (state_q == ST_EMIT) ? rd.base : '0;
    region_size_o   = (state_q == ST_EMIT) ? rd.size : '0;
    region_kind_o   = (state_q == ST_EMIT) ? rd.kind : '0;
    last_o          = (state_q == ST_EMPTY) || (i_q + one >= cnt_q);
    region_total_o  = 6'(cnt_q);
    usable_total_o  = us_q;
    mapped_total_o  = mp_q;
    dropped_count_o = drop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; drop_q <= '0;
      i_q <= '0; j_q <= '0; b_q <= '0; nb_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; drop_q <= drop_d;
      i_q <= i_d; j_q <= j_d; b_q <= b_d; nb_q <= nb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; t_q <= t_d; us_q <= us_d; mp_q <= mp_d;
  end

  // Checks.
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxRegions)) else $error("entry count overflow");
  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> i_q < cnt_q) else $error("emit past end");
  a_drop_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(drop_q) == 16'hFFFF && $past(state_q) != ST_IDLE |-> drop_q == 16'hFFFF)
    else $error("drop counter wrapped");

endmodule
